### rtl/motor_feedback_turn_tracker_macros.svh
// Assertion macros for the turn tracker RTL.
`ifndef MOTOR_FEEDBACK_TURN_TRACKER_MACROS_SVH
`define MOTOR_FEEDBACK_TURN_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define MFT_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define MFT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define MFT_ASSERT_SAME(label, pre, post, msg)
`define MFT_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

### rtl/mft_pkg.sv
// Types, constants and fixed-point helpers of the motor feedback turn tracker.
`timescale 1ns / 1ps
package mft_pkg;

    // Motor kinds (frame layouts)
    localparam logic [1:0] KIND_TORQUE = 2'd0;
    localparam logic [1:0] KIND_GIMBAL = 2'd1;
    localparam logic [1:0] KIND_GEARED = 2'd2;
    localparam logic [1:0] KIND_JOINT  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_MOTOR_KIND  = 1'b0;
    localparam logic CFG_ZERO_OFFSET = 1'b1;

    localparam logic [3:0] FRAME_BYTES   = 4'd8;
    localparam logic [7:0] TORQUE_HEADER = 8'hA1;

    // Q16.16 degrees
    localparam logic signed [31:0] DEG360 = 32'sd23592960;
    localparam logic signed [31:0] DEG180 = 32'sd11796480;

    localparam logic signed [16:0] THR_TORQUE = 17'sd8192;
    localparam logic signed [16:0] THR_GIMBAL = 17'sd5500;
    localparam logic signed [16:0] THR_GEARED = 17'sd4096;
    localparam logic signed [15:0] JOINT_EDGE = 16'sd17800;
    localparam logic signed [31:0] GEARED_TURN_LIMIT = 32'sd10000;

    typedef struct packed {
        logic [63:0] frame_data;
        logic [3:0]  frame_length;
    } frame_t;

    typedef struct packed {
        logic        index;
        logic [25:0] value;
    } cfg_t;

    typedef struct packed {
        logic               accepted;
        logic [15:0]        raw_angle;
        logic signed [31:0] speed_value;
        logic signed [31:0] current_value;
        logic signed [31:0] temperature;
        logic [7:0]         error_code;
        logic signed [31:0] turn_count;
        logic signed [47:0] continuous_angle;
        logic signed [31:0] limited_angle;
    } out_t;

    // Decoded frame, independent of the tracking state
    typedef struct packed {
        logic               reject;
        logic [15:0]        code;
        logic signed [31:0] base;
        logic signed [31:0] speed;
        logic signed [31:0] current;
        logic signed [31:0] temp;
        logic [7:0]         err;
    } dec_t;

    // round(v * 65536 / 100), half away from zero; v*16384/25 split as
    // v*655 + (v*9 + 12)/25, the small quotient by reciprocal 671089 / 2^24
    function automatic logic signed [31:0] div100_q16(logic signed [15:0] v);
        logic [15:0] mag;
        logic [19:0] y;
        logic [39:0] p;
        logic [24:0] res;
        mag = v[15] ? (~v + 16'd1) : v;
        y   = 20'(mag) * 20'd9 + 20'd12;
        p   = 40'(y) * 40'd671089;
        res = 25'(mag) * 25'd655 + 25'(p[39:24]);
        return v[15] ? -$signed(32'(res)) : $signed(32'(res));
    endfunction

    // round(v * 0.010472 * 65536), half away from zero; v*10723328/15625
    // split as v*686 + (v*4578 + 7812)/15625, reciprocal 281474977 / 2^42
    function automatic logic signed [31:0] speed_q16(logic signed [15:0] v);
        logic [15:0] mag;
        logic [27:0] y;
        logic [56:0] p;
        logic [24:0] res;
        mag = v[15] ? (~v + 16'd1) : v;
        y   = 28'(mag) * 28'd4578 + 28'd7812;
        p   = 57'(y) * 57'd281474977;
        res = 25'(mag) * 25'd686 + 25'(p[56:42]);
        return v[15] ? -$signed(32'(res)) : $signed(32'(res));
    endfunction

    // Keep the single-turn angle within half a turn of the offset
    function automatic logic signed [33:0] wrap_limited(logic signed [33:0] lim,
                                                        logic signed [33:0] off);
        logic signed [33:0] res;
        res = lim;
        if (lim < off - 34'(DEG180) && off >= 34'(DEG180))
            res = lim + 34'(DEG360);
        else if (lim > off + 34'(DEG180) && off < 34'(DEG180))
            res = lim - 34'(DEG360);
        return res;
    endfunction

endpackage

### rtl/mft_stream_if.sv
// Valid/ready channel carrying one payload word per handshake.
`timescale 1ns / 1ps
interface mft_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/mft_decode.sv
// Field decode of one feedback frame for the selected motor kind.
`timescale 1ns / 1ps
module mft_decode
(
    input  logic [1:0]      kind,
    input  mft_pkg::frame_t frame,
    output mft_pkg::dec_t   dec
);

    logic [7:0]         b [0:7];
    logic [15:0]        code_le;
    logic [15:0]        code_be;
    logic signed [15:0] s_a;
    logic signed [15:0] s_b;
    logic signed [15:0] s_c;
    logic signed [31:0] s32;
    logic signed [8:0]  t_ofs;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            b[i] = frame.frame_data[8*i +: 8];
        end
    end

    assign code_le = {b[7], b[6]};
    assign code_be = {b[0], b[1]};

    always_comb
    begin
        dec        = '0;
        s_a        = '0;
        s_b        = '0;
        s_c        = '0;
        s32        = '0;
        t_ofs      = '0;
        dec.reject = (frame.frame_length != mft_pkg::FRAME_BYTES);
        case (kind)
            mft_pkg::KIND_TORQUE:
            begin
                if (b[0] != mft_pkg::TORQUE_HEADER)
                begin
                    dec.reject = 1'b1;
                end
                s_a         = $signed({b[3], b[2]});
                s_b         = $signed({b[5], b[4]});
                s32         = 32'(s_a);
                dec.code    = code_le;
                dec.temp    = $signed({8'd0, b[1], 16'd0});
                dec.current = (s32 <<< 11) + (s32 <<< 6);
                dec.speed   = $signed({s_b, 16'd0});
                dec.base    = $signed(32'(code_le) * 32'd1440);
            end
            mft_pkg::KIND_GIMBAL:
            begin
                dec.code    = code_be;
                dec.speed   = $signed({b[2], b[3], 16'd0});
                dec.current = $signed({b[4], b[5], 16'd0});
                dec.temp    = $signed({8'd0, b[6], 16'd0});
                dec.base    = $signed(32'(code_be) * 32'd2880);
            end
            mft_pkg::KIND_GEARED:
            begin
                dec.code    = code_be;
                dec.speed   = $signed({b[2], b[3], 16'd0});
                dec.current = $signed({b[4], b[5], 16'd0});
                dec.base    = $signed(32'(code_be) * 32'd80);
            end
            mft_pkg::KIND_JOINT:
            begin
                s_a         = $signed(code_be);
                s_b         = $signed({b[2], b[3]});
                s_c         = $signed({b[4], b[5]});
                t_ofs       = $signed({1'b0, b[6]}) - 9'sd50;
                dec.code    = code_be;
                dec.base    = mft_pkg::div100_q16(s_a) + mft_pkg::DEG180;
                dec.speed   = mft_pkg::speed_q16(s_b);
                dec.current = mft_pkg::div100_q16(s_c);
                dec.temp    = $signed({{8{t_ofs[8]}}, t_ofs, 15'd0});
                dec.err     = b[7];
            end
            default:
            begin
                dec.reject = 1'b1;
            end
        endcase
    end

endmodule

### rtl/motor_feedback_turn_tracker.sv
// Top level of the motor feedback turn tracker.
`timescale 1ns / 1ps
`include "motor_feedback_turn_tracker_macros.svh"
// Takes one 8-byte feedback frame per word on frame, decodes it in the layout
// of the motor kind held in configuration register 0, counts whole turns from
// jumps of the angle code and returns one result word per frame on result.
// A frame is taken every cycle unless a stall on result.ready has filled the
// stages; it passes an input register, a decode register (constant-multiply
// scaling, no state involved) and the result register, where the turn count,
// stored angle code and offset change as the result register loads. Frames keep
// flowing while a result waits on result.ready as long as a stage is free.
// Rejected frames (length not 8, or a bad command byte on the torque-loop kind)
// return an all-zero word and leave the tracking state alone. Writing register 1
// (zero_offset) also reloads the working offset; write configuration only while
// no frame is in flight.
module motor_feedback_turn_tracker
(
    input logic        clk,
    input logic        rst_n,
    mft_stream_if.sink   frame,
    mft_stream_if.source result,
    mft_stream_if.sink   cfg
);

    // Configuration and tracking state
    logic [1:0]         kind_reg;
    logic signed [31:0] eff_reg;
    logic signed [31:0] eff_next;
    logic signed [31:0] turns_reg;
    logic signed [31:0] turns_next;
    logic [15:0]        prev_reg;
    logic               seen_reg;
    logic               seen_next;

    // Pipeline
    mft_pkg::frame_t frame_reg;
    logic            s1_valid_reg;
    mft_pkg::dec_t   dec_reg;
    mft_pkg::dec_t   dec_next;
    logic            s2_valid_reg;
    mft_pkg::out_t   res_reg;
    mft_pkg::out_t   res_next;
    logic            out_valid_reg;

    logic s1_load;
    logic s2_load;
    logic out_load;

    assign out_load    = s2_valid_reg && (!out_valid_reg || result.ready);
    assign s2_load     = s1_valid_reg && (!s2_valid_reg || out_load);
    assign frame.ready = !s1_valid_reg || s2_load;
    assign s1_load     = frame.valid && frame.ready;
    assign cfg.ready   = 1'b1;

    assign result.valid = out_valid_reg;
    assign result.data  = res_reg;

    mft_decode u_decode
    (
        .kind  (kind_reg),
        .frame (frame_reg),
        .dec   (dec_next)
    );

    // Tracking step for the word in the decode register
    logic [15:0]        last_code;
    logic signed [16:0] diff;
    logic signed [16:0] thr;
    logic               step_up;
    logic               step_down;
    logic signed [31:0] turns_step;
    logic signed [31:0] off;
    logic signed [31:0] sum32;
    logic [31:0]        tmul;
    logic signed [33:0] lim_raw;
    logic signed [33:0] lim_w;
    logic [47:0]        cont;

    always_comb
    begin
        eff_next   = eff_reg;
        seen_next  = seen_reg;
        turns_next = turns_reg;
        last_code  = prev_reg;
        thr        = mft_pkg::THR_TORQUE;
        diff       = '0;
        step_up    = 1'b0;
        step_down  = 1'b0;
        turns_step = turns_reg;
        off        = eff_reg;
        sum32      = '0;
        tmul       = '0;
        lim_raw    = '0;
        lim_w      = '0;
        cont       = '0;
        res_next   = '0;

        case (kind_reg)
            mft_pkg::KIND_TORQUE:
            begin
                last_code = prev_reg;
                thr       = mft_pkg::THR_TORQUE;
            end
            mft_pkg::KIND_GIMBAL:
            begin
                last_code = seen_reg ? prev_reg : dec_reg.code;
                thr       = mft_pkg::THR_GIMBAL;
            end
            mft_pkg::KIND_GEARED:
            begin
                last_code = seen_reg ? prev_reg : dec_reg.code;
                thr       = mft_pkg::THR_GEARED;
            end
            mft_pkg::KIND_JOINT:
            begin
                last_code = seen_reg ? prev_reg : dec_reg.code;
                thr       = mft_pkg::THR_TORQUE;
            end
            default:
            begin
                last_code = prev_reg;
            end
        endcase

        diff = $signed({1'b0, dec_reg.code}) - $signed({1'b0, last_code});
        if (kind_reg == mft_pkg::KIND_JOINT)
        begin
            // Turn crossing between the +178 and -178 degree ends
            step_up   = ($signed(last_code) > mft_pkg::JOINT_EDGE) &&
                        ($signed(dec_reg.code) < -mft_pkg::JOINT_EDGE);
            step_down = ($signed(last_code) < -mft_pkg::JOINT_EDGE) &&
                        ($signed(dec_reg.code) > mft_pkg::JOINT_EDGE);
        end
        else
        begin
            step_up   = diff < -thr;
            step_down = diff > thr;
        end

        if (step_up)
            turns_step = turns_reg + 32'sd1;
        else if (step_down)
            turns_step = turns_reg - 32'sd1;
        else
            turns_step = turns_reg;

        // Joint kind: shift the offset by a turn on a first frame in the upper half
        if (kind_reg == mft_pkg::KIND_JOINT && !seen_reg && !dec_reg.code[15])
            off = eff_reg - mft_pkg::DEG360;
        else
            off = eff_reg;

        res_next.accepted      = 1'b1;
        res_next.raw_angle     = dec_reg.code;
        res_next.speed_value   = dec_reg.speed;
        res_next.current_value = dec_reg.current;
        res_next.temperature   = dec_reg.temp;
        res_next.error_code    = dec_reg.err;

        case (kind_reg)
            mft_pkg::KIND_TORQUE:
            begin
                lim_raw = 34'(dec_reg.base) + 34'(off);
                tmul    = turns_step * 32'd360;
                cont    = {tmul, 16'd0} + 48'(lim_raw);
                lim_w   = mft_pkg::wrap_limited(lim_raw, 34'(off));
                turns_next = turns_step;
            end
            mft_pkg::KIND_GIMBAL:
            begin
                lim_raw = 34'(dec_reg.base);
                tmul    = turns_step * 32'd360;
                cont    = {tmul, 16'd0} + 48'(lim_raw);
                lim_w   = mft_pkg::wrap_limited(lim_raw, 34'(off));
                turns_next = turns_step;
                seen_next  = 1'b1;
            end
            mft_pkg::KIND_GEARED:
            begin
                tmul = turns_step * 32'd10;
                // Drop the turn count once it leaves the allowed range
                if (turns_step > mft_pkg::GEARED_TURN_LIMIT ||
                    turns_step < -mft_pkg::GEARED_TURN_LIMIT)
                begin
                    cont       = 48'(dec_reg.base);
                    turns_next = '0;
                end
                else
                begin
                    cont       = {tmul, 16'd0} + 48'(dec_reg.base);
                    turns_next = turns_step;
                end
                lim_w     = '0;
                seen_next = 1'b1;
            end
            mft_pkg::KIND_JOINT:
            begin
                sum32   = dec_reg.base + off;
                lim_raw = 34'(sum32);
                tmul    = turns_step * 32'd360;
                cont    = {tmul, 16'd0} + 48'(lim_raw);
                lim_w   = lim_raw;
                turns_next = turns_step;
                seen_next  = 1'b1;
                eff_next   = off;
            end
            default:
            begin
                turns_next = turns_reg;
            end
        endcase

        res_next.turn_count       = turns_next;
        res_next.continuous_angle = $signed(cont);
        res_next.limited_angle    = lim_w[31:0];

        // Rejected word: zero result, hold state
        if (dec_reg.reject)
        begin
            res_next   = '0;
            turns_next = turns_reg;
            seen_next  = seen_reg;
            eff_next   = eff_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (s2_load)
                s1_valid_reg <= 1'b0;
            if (s2_load)
                s2_valid_reg <= 1'b1;
            else if (out_load)
                s2_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
            frame_reg <= frame.data;
        if (s2_load)
            dec_reg <= dec_next;
        if (out_load)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= mft_pkg::KIND_TORQUE;
            eff_reg   <= '0;
            turns_reg <= '0;
            prev_reg  <= '0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.data.index)
                    mft_pkg::CFG_MOTOR_KIND:
                    begin
                        kind_reg <= cfg.data.value[1:0];
                    end
                    mft_pkg::CFG_ZERO_OFFSET:
                    begin
                        eff_reg <= 32'($signed(cfg.data.value));
                    end
                    default:
                    begin
                        kind_reg <= kind_reg;
                    end
                endcase
            end
            else if (out_load)
            begin
                eff_reg <= eff_next;
            end
            if (out_load)
            begin
                turns_reg <= turns_next;
                seen_reg  <= seen_next;
                if (!dec_reg.reject)
                    prev_reg <= dec_reg.code;
            end
        end
    end

    `MFT_ASSERT_NEXT(a_reject_holds_state, out_load && dec_reg.reject, (turns_reg == $past(turns_reg)) && (prev_reg == $past(prev_reg)) && (seen_reg == $past(seen_reg)), "rejected word changed tracking state")
    `MFT_ASSERT_NEXT(a_turn_single_step, out_load && !dec_reg.reject && (kind_reg != mft_pkg::KIND_GEARED), (turns_reg == $past(turns_reg)) || (turns_reg == $past(turns_reg) + 32'sd1) || (turns_reg == $past(turns_reg) - 32'sd1), "turn count moved more than one turn")
    `MFT_ASSERT_NEXT(a_result_turns, out_load, out_valid_reg && (!res_reg.accepted || (res_reg.turn_count == turns_reg)), "result turn count differs from state")
    `MFT_ASSERT_NEXT(a_seen_sticky, seen_reg, seen_reg, "first-frame flag cleared")

endmodule

### bench/turn_tracker_checker.sv
// Checker for the turn tracker: predicts every result word and compares it with the block.
`timescale 1ns / 1ps
module turn_tracker_checker
    import mft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic frame_valid,
    input  logic frame_ready,
    input  frame_t frame_word,
    input  logic result_valid,
    input  logic result_ready,
    input  out_t result_word,
    input  logic cfg_valid,
    input  logic cfg_ready,
    input  cfg_t cfg_word,
    output int   failures
);

    localparam longint FULL_TURN = longint'(DEG360);
    localparam longint HALF_TURN = longint'(DEG180);

    // Tracking state as the block should hold it
    logic [1:0]  kind_reg;
    logic [31:0] work_offset;
    logic [15:0] last_code;
    logic [31:0] turn_reg;
    bit          primed;

    out_t pending_readings[$];
    out_t want;
    int   outstanding = 0;
    int   mismatches = 0;

    assign failures = mismatches + outstanding;

    function automatic longint round_div(longint num, longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    // Keep the single-turn angle within half a turn of the offset
    function automatic longint wrap_near(longint lim, longint off);
        if (lim < off - HALF_TURN && off >= HALF_TURN)
            return lim + FULL_TURN;
        if (lim > off + HALF_TURN && off < HALF_TURN)
            return lim - FULL_TURN;
        return lim;
    endfunction

    // Decode one frame, advance the turn state and return the reading it yields
    function automatic out_t track_frame(frame_t f);
        out_t        r;
        logic [7:0]  bt [0:7];
        logic [15:0] code;
        logic [31:0] low_word;
        longint      diff, thr, t, off, lim, cont, speed, cur, temp, ang, c, lastc;
        logic [7:0]  err;
        int          i;
        r = '0;
        for (i = 0; i < 8; i++)
            bt[i] = f.frame_data[8*i +: 8];
        if (f.frame_length != FRAME_BYTES)
            return r;
        if (kind_reg == KIND_TORQUE && bt[0] != TORQUE_HEADER)
            return r;
        off = longint'($signed(work_offset));
        err = 8'h00;
        temp = 0;
        case (kind_reg)
            KIND_TORQUE:
            begin
                code = {bt[7], bt[6]};
                temp = longint'(bt[1]) * 65536;
                cur = longint'($signed({bt[3], bt[2]})) * 2112;
                speed = longint'($signed({bt[5], bt[4]})) * 65536;
                diff = longint'(code) - longint'(last_code);
                if (diff < -longint'(THR_TORQUE))
                    turn_reg = turn_reg + 32'd1;
                else if (diff > longint'(THR_TORQUE))
                    turn_reg = turn_reg - 32'd1;
                t = longint'($signed(turn_reg));
                lim = longint'(code) * 1440 + off;
                cont = t * FULL_TURN + lim;
                lim = wrap_near(lim, off);
            end
            KIND_GIMBAL, KIND_GEARED:
            begin
                code = {bt[0], bt[1]};
                thr = (kind_reg == KIND_GIMBAL) ? longint'(THR_GIMBAL) : longint'(THR_GEARED);
                speed = longint'($signed({bt[2], bt[3]})) * 65536;
                cur = longint'($signed({bt[4], bt[5]})) * 65536;
                diff = longint'(code) - (primed ? longint'(last_code) : longint'(code));
                if (diff < -thr)
                    turn_reg = turn_reg + 32'd1;
                else if (diff > thr)
                    turn_reg = turn_reg - 32'd1;
                primed = 1'b1;
                t = longint'($signed(turn_reg));
                if (kind_reg == KIND_GIMBAL)
                begin
                    temp = longint'(bt[6]) * 65536;
                    lim = longint'(code) * 2880;
                    cont = t * FULL_TURN + lim;
                    lim = wrap_near(lim, off);
                end
                else
                begin
                    cont = t * 655360 + longint'(code) * 80;
                    // drop the whole turns once the count runs past the limit
                    if (t > longint'(GEARED_TURN_LIMIT) || t < -longint'(GEARED_TURN_LIMIT))
                    begin
                        cont = cont - t * 655360;
                        turn_reg = '0;
                    end
                    lim = 0;
                end
            end
            default:
            begin
                code = {bt[0], bt[1]};
                c = longint'($signed(code));
                lastc = primed ? longint'($signed(last_code)) : c;
                ang = round_div(c * 65536, 100) + HALF_TURN;
                speed = round_div(longint'($signed({bt[2], bt[3]})) * 10472 * 65536, 1000000);
                cur = round_div(longint'($signed({bt[4], bt[5]})) * 65536, 100);
                temp = (longint'(bt[6]) - 50) * 32768;
                err = bt[7];
                // first frame in the upper half moves the offset down a full turn
                if (!primed && c >= 0)
                begin
                    work_offset = work_offset - 32'(DEG360);
                    off = longint'($signed(work_offset));
                end
                primed = 1'b1;
                if (lastc > longint'(JOINT_EDGE) && c < -longint'(JOINT_EDGE))
                    turn_reg = turn_reg + 32'd1;
                else if (lastc < -longint'(JOINT_EDGE) && c > longint'(JOINT_EDGE))
                    turn_reg = turn_reg - 32'd1;
                t = longint'($signed(turn_reg));
                low_word = 32'(ang + off);
                lim = longint'($signed(low_word));
                cont = t * FULL_TURN + lim;
            end
        endcase
        last_code = code;
        r.accepted = 1'b1;
        r.raw_angle = code;
        r.speed_value = speed[31:0];
        r.current_value = cur[31:0];
        r.temperature = temp[31:0];
        r.error_code = err;
        r.turn_count = turn_reg;
        r.continuous_angle = cont[47:0];
        r.limited_angle = lim[31:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg = KIND_TORQUE;
            work_offset = '0;
            last_code = '0;
            turn_reg = '0;
            primed = 1'b0;
        end
        else
        begin
            // a result word never belongs to the frame taken at the same edge
            if (result_valid && result_ready)
            begin
                if (outstanding == 0)
                begin
                    $error("result word arrived with no reading outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    outstanding--;
                    check_field("accepted", want.accepted, result_word.accepted);
                    check_field("raw_angle", want.raw_angle, result_word.raw_angle);
                    check_field("speed_value", want.speed_value, result_word.speed_value);
                    check_field("current_value", want.current_value,
                                result_word.current_value);
                    check_field("temperature", want.temperature, result_word.temperature);
                    check_field("error_code", want.error_code, result_word.error_code);
                    check_field("turn_count", want.turn_count, result_word.turn_count);
                    check_field("continuous_angle", want.continuous_angle,
                                result_word.continuous_angle);
                    check_field("limited_angle", want.limited_angle,
                                result_word.limited_angle);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_word.index == CFG_MOTOR_KIND)
                    kind_reg = cfg_word.value[1:0];
                else
                    work_offset = 32'($signed(cfg_word.value));
            end
            if (frame_valid && frame_ready)
            begin
                pending_readings.push_back(track_frame(frame_word));
                outstanding++;
            end
        end
    end

endmodule

### bench/testbench.sv
// Top of the turn tracker bench: clock, reset, frame stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module testbench;
    import mft_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int LONG_HOLD    = 300;
    localparam int PHASES       = 14;
    localparam int PHASE_FRAMES = 44;
    localparam int SPIN_TURNS   = 10050;

    logic clk;
    logic rst_n;

    mft_stream_if #(.payload_t(frame_t)) frame_ch ();
    mft_stream_if #(.payload_t(out_t))   result_ch ();
    mft_stream_if #(.payload_t(cfg_t))   cfg_ch ();

    int failures;
    int frames_in = 0;
    int results_out = 0;
    int quiet_cycles = 0;

    bit          calm = 1'b0;
    bit          gaps_on = 1'b0;
    bit          hold_long = 1'b0;
    logic [15:0] last_sent_code = '0;
    logic [1:0]  phase_kind;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    motor_feedback_turn_tracker dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    turn_tracker_checker checker_inst
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_ch.valid),
        .frame_ready  (frame_ch.ready),
        .frame_word   (frame_ch.data),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .result_word  (result_ch.data),
        .cfg_valid    (cfg_ch.valid),
        .cfg_ready    (cfg_ch.ready),
        .cfg_word     (cfg_ch.data),
        .failures     (failures)
    );

    // Count words both ways; end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (frame_ch.valid && frame_ch.ready)
            frames_in <= frames_in + 1;
        if (result_ch.valid && result_ch.ready)
            results_out <= results_out + 1;
        if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls, one long hold on request, none once calm
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_long <= 1'b0;
                result_ch.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    function automatic logic [63:0] pack_frame(input logic [1:0] kind, input logic [15:0] code,
                                               input logic [15:0] spd, input logic [15:0] cur,
                                               input logic [7:0] tmp, input logic [7:0] err);
        if (kind == KIND_TORQUE)
            return {code, spd, cur, tmp, TORQUE_HEADER};
        return {err, tmp, cur[7:0], cur[15:8], spd[7:0], spd[15:8], code[7:0], code[15:8]};
    endfunction

    function automatic logic [15:0] pick_field();
        logic [15:0] corners [0:3] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 3)];
        return 16'($urandom);
    endfunction

    // Mix of jumps across the turn boundary, threshold steps and joint edges
    function automatic logic [15:0] pick_code(input logic [1:0] kind, input logic [15:0] prev);
        logic [15:0] corners [0:3] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
        int thr;
        int sgn;
        thr = (kind == KIND_TORQUE) ? 8192 : (kind == KIND_GIMBAL) ? 5500 : 4096;
        sgn = ($urandom_range(0, 1) == 1) ? 1 : -1;
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'(int'(prev) + int'($urandom_range(0, 12000)) - 6000);
            2: return prev[15] ? 16'($urandom_range(0, 2000)) : 16'(65535 - $urandom_range(0, 2000));
            3: return 16'(sgn * int'($urandom_range(17790, 17810)));
            4:
            begin
                if (kind == KIND_JOINT)
                    return 16'(sgn * int'($urandom_range(17800, 32768)));
                return 16'(int'(prev) + sgn * (thr + int'($urandom_range(0, 2)) - 1));
            end
            default: return corners[$urandom_range(0, 3)];
        endcase
    endfunction

    function automatic logic [25:0] pick_offset();
        case ($urandom_range(0, 6))
            0: return 26'(-23592960);
            1: return 26'(23592960);
            2: return 26'd0;
            3: return 26'(DEG180);
            4: return 26'(DEG180 - 1);
            5: return 26'(-DEG180);
            default: return 26'(int'($urandom_range(0, 47185920)) - 23592960);
        endcase
    endfunction

    // Offer one frame word and hold it until taken; enter and leave on a falling edge
    task automatic send_raw(input logic [63:0] data, input logic [3:0] len);
        if (gaps_on && !calm && $urandom_range(0, 5) == 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        frame_ch.valid <= 1'b1;
        frame_ch.data <= {data, len};
        do
            @(posedge clk);
        while (!frame_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic [15:0] code,
                               input logic [15:0] spd, input logic [15:0] cur,
                               input logic [7:0] tmp, input logic [7:0] err);
        last_sent_code = code;
        send_raw(pack_frame(kind, code, spd, cur, tmp, err), FRAME_BYTES);
    endtask

    task automatic send_random(input logic [1:0] kind);
        logic [15:0] code;
        logic [63:0] data;
        logic [3:0]  len;
        logic [7:0]  head;
        code = pick_code(kind, last_sent_code);
        data = pack_frame(kind, code, pick_field(), pick_field(), 8'($urandom), 8'($urandom));
        len = FRAME_BYTES;
        case ($urandom_range(0, 19))
            0, 1: len = 4'($urandom_range(0, 15));
            2: data = {$urandom, $urandom};
            3:
            begin
                head = 8'($urandom);
                if (head == TORQUE_HEADER)
                    head = 8'h00;
                if (kind == KIND_TORQUE)
                    data[7:0] = head;
            end
            default: ;
        endcase
        last_sent_code = code;
        send_raw(data, len);
    endtask

    // Stop offering frames and wait until every reading is back
    task automatic drain();
        frame_ch.valid <= 1'b0;
        while (results_out != frames_in)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [25:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= {idx, value};
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    task automatic configure(input logic [1:0] kind, input logic [25:0] offset,
                             input bit load_offset);
        drain();
        write_reg(CFG_MOTOR_KIND, 26'(kind));
        if (load_offset)
            write_reg(CFG_ZERO_OFFSET, offset);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drive the joint angle across the edge once per three frames
    task automatic spin_joint(input bit upward, input int turns_wanted);
        logic [15:0] high_code;
        logic [15:0] low_code;
        repeat (turns_wanted)
        begin
            high_code = 16'($urandom_range(17801, 32767));
            low_code = 16'(-int'($urandom_range(17801, 32768)));
            if (upward)
            begin
                send_fields(KIND_JOINT, high_code, pick_field(), pick_field(),
                            8'($urandom), 8'($urandom));
                send_fields(KIND_JOINT, low_code, pick_field(), pick_field(),
                            8'($urandom), 8'($urandom));
            end
            else
            begin
                send_fields(KIND_JOINT, low_code, pick_field(), pick_field(),
                            8'($urandom), 8'($urandom));
                send_fields(KIND_JOINT, high_code, pick_field(), pick_field(),
                            8'($urandom), 8'($urandom));
            end
            send_fields(KIND_JOINT, 16'(int'($urandom_range(0, 100)) - 50), pick_field(),
                        pick_field(), 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        frame_ch.valid = 1'b0;
        frame_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // joint first, while no frame has been seen yet
        configure(KIND_JOINT, pick_offset(), 1'b1);
        gaps_on = 1'b1;
        send_fields(KIND_JOINT, 16'($urandom), 16'h7FFF, 16'h8000, 8'h00, 8'hFF);
        send_fields(KIND_JOINT, 16'h4589, 16'h8000, 16'h7FFF, 8'hFF, 8'h00);
        send_fields(KIND_JOINT, 16'hBA77, 16'h7FFF, 16'h8000, 8'd50, 8'h5A);
        send_fields(KIND_JOINT, 16'h4589, 16'h0001, 16'hFFFF, 8'd49, 8'hA5);
        send_fields(KIND_JOINT, 16'h4588, 16'hFFFF, 16'h0001, 8'd51, 8'h01);
        send_fields(KIND_JOINT, 16'hBA78, 16'h0000, 16'h0000, 8'h80, 8'h80);
        send_fields(KIND_JOINT, 16'h8000, 16'h1234, 16'hEDCB, 8'h7F, 8'hFE);
        send_fields(KIND_JOINT, 16'h7FFF, 16'h0032, 16'hFFCE, 8'h01, 8'h7F);
        send_raw({$urandom, $urandom}, 4'd7);
        send_raw({$urandom, $urandom}, 4'd0);
        send_raw({$urandom, $urandom}, 4'd15);

        configure(KIND_TORQUE, 26'(23592960), 1'b1);
        send_raw(pack_frame(KIND_TORQUE, 16'h1000, 16'h0, 16'h0, 8'h0, 8'h0) ^ 64'h1,
                 FRAME_BYTES);
        send_fields(KIND_TORQUE, 16'h0000, 16'h7FFF, 16'h8000, 8'hFF, 8'h00);
        send_fields(KIND_TORQUE, 16'hFFFF, 16'h8000, 16'h7FFF, 8'h00, 8'h00);
        send_fields(KIND_TORQUE, 16'h0000, 16'hFFFF, 16'h0001, 8'h7F, 8'h00);
        send_fields(KIND_TORQUE, 16'd8192, 16'h0001, 16'hFFFF, 8'h80, 8'h00);
        send_fields(KIND_TORQUE, 16'd16385, 16'h0000, 16'h0000, 8'h01, 8'h00);

        configure(KIND_GIMBAL, 26'(-23592960), 1'b1);
        send_fields(KIND_GIMBAL, 16'd100, 16'h7FFF, 16'h8000, 8'hFF, 8'hFF);
        send_fields(KIND_GIMBAL, 16'd5600, 16'h8000, 16'h7FFF, 8'h00, 8'h00);
        send_fields(KIND_GIMBAL, 16'd11101, 16'h0001, 16'hFFFF, 8'h55, 8'h00);
        send_fields(KIND_GIMBAL, 16'd0, 16'hFFFF, 16'h0001, 8'hAA, 8'h00);
        send_fields(KIND_GIMBAL, 16'hFFFF, 16'h0000, 16'h0000, 8'h01, 8'h00);

        configure(KIND_GEARED, 26'(DEG180), 1'b1);
        send_fields(KIND_GEARED, 16'd0, 16'h7FFF, 16'h8000, 8'hFF, 8'hFF);
        send_fields(KIND_GEARED, 16'd4096, 16'h8000, 16'h7FFF, 8'h00, 8'h00);
        send_fields(KIND_GEARED, 16'd8193, 16'hFFFF, 16'h0001, 8'h00, 8'h00);
        send_fields(KIND_GEARED, 16'd0, 16'h0001, 16'hFFFF, 8'h00, 8'h00);

        // run the count past the geared limit both ways, then let geared clear it
        gaps_on = 1'b0;
        configure(KIND_JOINT, pick_offset(), 1'b0);
        spin_joint(1'b1, SPIN_TURNS);
        configure(KIND_GEARED, pick_offset(), 1'b0);
        repeat (8) send_random(KIND_GEARED);
        configure(KIND_JOINT, pick_offset(), 1'b0);
        spin_joint(1'b0, SPIN_TURNS);
        configure(KIND_GEARED, pick_offset(), 1'b0);
        repeat (8) send_random(KIND_GEARED);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            phase_kind = 2'($urandom_range(0, 3));
            configure(phase_kind, pick_offset(), $urandom_range(0, 2) != 0);
            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase == 2)
                hold_long <= 1'b1;
            if (phase == PHASES - 1)
                calm = 1'b1;
            repeat (PHASE_FRAMES) send_random(phase_kind);
        end

        drain();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### motor_feedback_turn_tracker.f
+incdir+rtl
rtl/mft_pkg.sv
rtl/mft_stream_if.sv
rtl/mft_decode.sv
rtl/motor_feedback_turn_tracker.sv
bench/turn_tracker_checker.sv
bench/testbench.sv
